>>> hdl/wgr_pkg.sv
// ----------------------------------------------------------------------------
// wgr_pkg
// Shared constants, codes and types for the waveset group reverser.
// ----------------------------------------------------------------------------
package wgr_pkg;

  // Sizing
  localparam int BANK_DEPTH   = 4096;
  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_GROUP    = 64;
  localparam int IDX_W        = $clog2(BANK_DEPTH);      // entry index inside a bank
  localparam int LVL_W        = IDX_W + 1;               // level counts 0..BANK_DEPTH
  localparam int ADDR_W       = IDX_W + 1;               // bank select + index
  localparam int GRP_W        = 7;                       // group_cycles register
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;

  // Input item kinds
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_SAMPLE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SPLIT   = 2'd3;

  // Bank memory request
  typedef struct packed {
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [SAMPLE_WIDTH-1:0] wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
  } mem_req_t;

  // Result descriptor leaving the control stage
  typedef struct packed {
    logic                valid;
    logic                is_sample;   // data comes from the bank read
    logic                last;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

>>> hdl/wgr_bank_ram.sv
// ----------------------------------------------------------------------------
// wgr_bank_ram
// Ping-pong sample banks: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wgr_bank_ram
  import wgr_pkg::*;
(
  input  logic                    clk_i,
  input  mem_req_t                req_i,
  output logic [SAMPLE_WIDTH-1:0] rd_data_o
);

  logic [SAMPLE_WIDTH-1:0] mem [2*BANK_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/wgr_ctrl.sv
// ----------------------------------------------------------------------------
// wgr_ctrl
// Cycle tracking, bank levels and handover; issues bank write/read per item.
// ----------------------------------------------------------------------------
module wgr_ctrl
  import wgr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [GRP_W-1:0]        cfg_data_i,
  // accepted item
  input  logic                    item_fire_i,
  input  logic [MODE_W-1:0]       item_mode_i,
  input  logic [SAMPLE_WIDTH-1:0] item_sample_i,
  // to bank memory and result stage
  output mem_req_t                mem_req_o,
  output res_t                    res_o
);

  logic [GRP_W-1:0] group_cycles_q;
  logic             fill_sel_q, fill_sel_d;
  logic [LVL_W-1:0] fill_lvl_q, fill_lvl_d;
  logic [LVL_W-1:0] drain_lvl_q, drain_lvl_d;
  logic [GRP_W-1:0] cycles_q, cycles_d;
  logic             prev_neg_q, prev_neg_d;
  logic             started_q, started_d;

  logic [GRP_W-1:0] eff_group;
  logic             negative;
  logic             boundary;
  logic             close_grp;
  logic             bank_full;
  logic             hand_over;
  logic             overrun;
  logic [LVL_W-1:0] fill_base;
  logic [LVL_W-1:0] drain_dec;

  // Register clamped to 1..MAX_GROUP
  always_comb begin
    if (group_cycles_q == '0) begin
      eff_group = GRP_W'(1);
    end else if (group_cycles_q > GRP_W'(MAX_GROUP)) begin
      eff_group = GRP_W'(MAX_GROUP);
    end else begin
      eff_group = group_cycles_q;
    end
  end

  assign negative  = item_sample_i[SAMPLE_WIDTH-1];
  assign boundary  = started_q && prev_neg_q && !negative;
  assign close_grp = boundary && (cycles_q >= eff_group);
  // after a group close the fill bank is empty, so it cannot also be full
  assign bank_full = !close_grp && (fill_lvl_q >= LVL_W'(BANK_DEPTH));
  assign drain_dec = drain_lvl_q - LVL_W'(1);

  // Next state, memory request and result
  always_comb begin
    fill_sel_d  = fill_sel_q;
    fill_lvl_d  = fill_lvl_q;
    drain_lvl_d = drain_lvl_q;
    cycles_d    = cycles_q;
    prev_neg_d  = prev_neg_q;
    started_d   = started_q;
    hand_over   = 1'b0;
    fill_base   = fill_lvl_q;
    mem_req_o   = '0;
    res_o       = '0;
    overrun     = 1'b0;

    unique case (item_mode_i)
      MODE_PUSH: begin
        hand_over = close_grp || bank_full;
        if (!started_q) begin
          cycles_d = GRP_W'(1);
        end else if (hand_over) begin
          cycles_d = GRP_W'(1);
        end else if (boundary) begin
          cycles_d = cycles_q + GRP_W'(1);
        end
        started_d  = 1'b1;
        prev_neg_d = negative;
        if (hand_over) begin
          overrun     = (drain_lvl_q != '0);
          fill_sel_d  = ~fill_sel_q;
          drain_lvl_d = fill_lvl_q;
          fill_base   = '0;
        end
        fill_lvl_d        = fill_base + LVL_W'(1);
        mem_req_o.wr_en   = item_fire_i;
        mem_req_o.wr_addr = {fill_sel_d, fill_base[IDX_W-1:0]};
        mem_req_o.wr_data = item_sample_i;
        res_o.valid       = item_fire_i && (overrun || bank_full);
        res_o.status      = overrun ? ST_OVERRUN : ST_SPLIT;
      end
      MODE_FLUSH: begin
        hand_over = (fill_lvl_q != '0);
        if (hand_over) begin
          overrun     = (drain_lvl_q != '0);
          fill_sel_d  = ~fill_sel_q;
          drain_lvl_d = fill_lvl_q;
          fill_lvl_d  = '0;
        end
        started_d    = 1'b0;
        prev_neg_d   = 1'b0;
        cycles_d     = '0;
        res_o.valid  = item_fire_i && overrun;
        res_o.status = ST_OVERRUN;
      end
      MODE_DRAIN: begin
        res_o.valid = item_fire_i;
        if (drain_lvl_q == '0 || drain_lvl_q > LVL_W'(BANK_DEPTH)) begin
          drain_lvl_d  = '0;
          res_o.status = ST_EMPTY;
        end else begin
          drain_lvl_d       = drain_dec;
          mem_req_o.rd_en   = item_fire_i;
          mem_req_o.rd_addr = {~fill_sel_q, drain_dec[IDX_W-1:0]};
          res_o.is_sample   = 1'b1;
          res_o.last        = (drain_dec == '0);
          res_o.status      = ST_SAMPLE;
        end
      end
      default: begin
        // unused kind: no state change, no result
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_cycles_q <= GRP_W'(1);
      fill_sel_q     <= 1'b0;
      fill_lvl_q     <= '0;
      drain_lvl_q    <= '0;
      cycles_q       <= '0;
      prev_neg_q     <= 1'b0;
      started_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        group_cycles_q <= cfg_data_i;
      end
      if (item_fire_i) begin
        fill_sel_q  <= fill_sel_d;
        fill_lvl_q  <= fill_lvl_d;
        drain_lvl_q <= drain_lvl_d;
        cycles_q    <= cycles_d;
        prev_neg_q  <= prev_neg_d;
        started_q   <= started_d;
      end
    end
  end

  // Levels and cycle count stay in range
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_lvl_q <= LVL_W'(BANK_DEPTH))
    else $error("fill level beyond bank depth");

  a_drain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_lvl_q <= LVL_W'(BANK_DEPTH))
    else $error("drain level beyond bank depth");

  a_cycles_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cycles_q <= GRP_W'(MAX_GROUP))
    else $error("cycle count beyond group limit");

  // A push always leaves a non-empty fill bank
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_fire_i && item_mode_i == MODE_PUSH |=> fill_lvl_q != '0)
    else $error("push left fill bank empty");

endmodule

>>> hdl/waveset_group_reverser_core.sv
// ----------------------------------------------------------------------------
// waveset_group_reverser_core
// Splits a Q1.15 stream into wavesets and plays groups of them back reversed.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: sample, tuser: mode
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: out_sample,
//                                                 tlast: group_last, tuser: status
//  cfg       in   cfg_valid_i / cfg_ready_o       cfg_data_i: group_cycles
//
// One item per cycle while the output is not stalled; each result is registered
// in the result stage, together with the bank read, and then in the output register.
// The bank memory has one write and one read port; pushes write, drain ticks read.
// Reset clears all control state; bank contents are undefined until written.
// A stalled output holds one result in the output register and one in the
// result stage before input ready drops.
// ----------------------------------------------------------------------------
module waveset_group_reverser_core
  import wgr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [15:0]             s_axis_tdata,   // [15:0] sample
  input  logic [7:0]              s_axis_tuser,   // [1:0] mode
  // output stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [15:0]             m_axis_tdata,   // [15:0] out_sample
  output logic                    m_axis_tlast,
  output logic [7:0]              m_axis_tuser,   // [1:0] status
  // configuration
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [GRP_W-1:0]        cfg_data_i
);

  logic                    item_fire;
  mem_req_t                mem_req;
  res_t                    res;
  res_t                    stage_q;
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic                    stage_adv;

  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_sample_q;
  logic                    out_last_q;
  logic [STATUS_W-1:0]     out_status_q;

  assign cfg_ready_o   = 1'b1;
  assign stage_adv     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !stage_q.valid || stage_adv;
  assign item_fire     = s_axis_tvalid && s_axis_tready;

  wgr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .item_fire_i   (item_fire),
    .item_mode_i   (s_axis_tuser[MODE_W-1:0]),
    .item_sample_i (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .mem_req_o     (mem_req),
    .res_o         (res)
  );

  wgr_bank_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Result stage, aligned with the bank read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (s_axis_tready) begin
      stage_q <= item_fire ? res : '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_adv) begin
      out_valid_q <= stage_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv && stage_q.valid) begin
      out_sample_q <= stage_q.is_sample ? rd_data : '0;
      out_last_q   <= stage_q.last;
      out_status_q <= stage_q.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {{(8-STATUS_W){1'b0}}, out_status_q};

  // Input stalls only while the result stage is occupied
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> stage_q.valid && out_valid_q)
    else $error("input stalled without pending results");

  // Non-sample results carry zero data and no group end
  a_nonsample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_status_q != ST_SAMPLE |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("status result with data or last set");

  // A blocked result stage keeps its descriptor
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q.valid && !stage_adv |=> $stable(stage_q))
    else $error("result stage changed while blocked");

endmodule

>>> bench/waveset_group_reverser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveset_group_reverser_core_tb
// Self-checking bench for the waveset group reverser core.
//
// A driver offers push, flush, drain and unused-mode transactions from a queue
// that the main sequence fills. Every accepted transaction runs through a
// behavioral copy of the reverser (banks, levels, cycle tracking, group size).
// The predicted outputs are then queued. The monitor pops that queue on each
// output transaction and compares sample, last flag and status.
// The sequence has a short directed part and a long output stall with drain
// ticks queued behind it. Random waveform phases then run over a range of
// group sizes, some of them with no idle cycles on either side.
// ----------------------------------------------------------------------------
module waveset_group_reverser_core_tb;
  import wgr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;   // exceeds the longest legal quiet stretch
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [SAMPLE_WIDTH-1:0] smp;
  } wave_item_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] smp;
    logic                    last;
    logic [STATUS_W-1:0]     status;
  } reverser_out_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [15:0]             s_axis_tdata = '0;   // [15:0] sample
  logic [7:0]              s_axis_tuser = '0;   // [1:0] mode
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [15:0]             m_axis_tdata;        // [15:0] out_sample
  logic                    m_axis_tlast;
  logic [7:0]              m_axis_tuser;        // [1:0] status
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [GRP_W-1:0]        cfg_data_i = '0;

  waveset_group_reverser_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Behavioral reverser state
  // --------------------------------------------------------------------------
  logic [SAMPLE_WIDTH-1:0] bank_mem [2*BANK_DEPTH];
  bit                      fill_sel  = 1'b0;
  int unsigned             fill_lvl  = 0;
  int unsigned             drain_lvl = 0;
  int unsigned             cyc_cnt   = 0;
  bit                      prev_neg  = 1'b0;
  bit                      started   = 1'b0;
  logic [GRP_W-1:0]        grp_reg   = 7'd1;

  reverser_out_t           predicted_out_q[$];
  wave_item_t              stim_q[$];

  int unsigned             mismatches   = 0;
  int unsigned             quiet_cycles = 0;
  bit                      no_idle       = 1'b0;
  bit                      stall_request = 1'b0;
  bit                      wave_neg      = 1'b0;
  bit                      offer;
  int unsigned             gap_left;
  int unsigned             stall_left;
  int unsigned             hold_left;

  logic [GRP_W-1:0] grp_plan [11] = '{7'd0, 7'd127, 7'd1, 7'd3, 7'd64, 7'd100,
                                      7'd2, 7'd5, 7'd17, 7'd42, 7'd85};

  // register values 0 and above 64 saturate
  function automatic int unsigned grp_limit();
    if (grp_reg == 0) return 1;
    if (grp_reg > MAX_GROUP) return MAX_GROUP;
    return grp_reg;
  endfunction

  // append one predicted output transaction
  function automatic void add_result(input logic [SAMPLE_WIDTH-1:0] smp, input logic last,
                                     input logic [STATUS_W-1:0] status);
    reverser_out_t r;
    r.smp    = smp;
    r.last   = last;
    r.status = status;
    predicted_out_q.insert(predicted_out_q.size(), r);
  endfunction

  // fill bank becomes the drain bank; returns 1 when unread samples are lost
  function automatic bit hand_bank_over();
    bit lost;
    lost      = (drain_lvl != 0);
    drain_lvl = fill_lvl;
    fill_lvl  = 0;
    fill_sel  = ~fill_sel;
    return lost;
  endfunction

  task automatic step_reverser(input wave_item_t it);
    bit lost;
    bit split;
    bit neg;
    lost  = 1'b0;
    split = 1'b0;
    case (it.mode)
      MODE_PUSH: begin
        neg = it.smp[SAMPLE_WIDTH-1];
        if (!started) begin
          started = 1'b1;
          cyc_cnt = 1;
        end else if (prev_neg && !neg) begin
          if (cyc_cnt >= grp_limit()) begin
            lost    = hand_bank_over();
            cyc_cnt = 1;
          end else begin
            cyc_cnt++;
          end
        end
        // full bank forces a split before the store
        if (fill_lvl >= BANK_DEPTH) begin
          if (hand_bank_over()) lost = 1'b1;
          split   = 1'b1;
          cyc_cnt = 1;
        end
        bank_mem[fill_sel ? BANK_DEPTH + fill_lvl : fill_lvl] = it.smp;
        fill_lvl++;
        prev_neg = neg;
        if (lost) add_result('0, 1'b0, ST_OVERRUN);
        else if (split) add_result('0, 1'b0, ST_SPLIT);
      end
      MODE_FLUSH: begin
        if (fill_lvl != 0) lost = hand_bank_over();
        started  = 1'b0;
        prev_neg = 1'b0;
        cyc_cnt  = 0;
        if (lost) add_result('0, 1'b0, ST_OVERRUN);
      end
      MODE_DRAIN: begin
        if (drain_lvl == 0) begin
          add_result('0, 1'b0, ST_EMPTY);
        end else begin
          drain_lvl--;
          add_result(bank_mem[fill_sel ? drain_lvl : BANK_DEPTH + drain_lvl],
                     drain_lvl == 0, ST_SAMPLE);
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      gap_left = 0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        step_reverser(stim_q.pop_front());
        offer    = 1'b0;
        gap_left = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          offer = 1'b1;
          s_axis_tdata <= stim_q[0].smp;
          s_axis_tuser <= {6'b0, stim_q[0].mode};
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor and checker
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input int unsigned exp_v, act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_out_q.size() == 0) begin
          note_mismatch("unexpected transaction, sample", 0, m_axis_tdata);
        end else begin
          if (m_axis_tdata !== predicted_out_q[0].smp)
            note_mismatch("out_sample", predicted_out_q[0].smp, m_axis_tdata);
          if (m_axis_tlast !== predicted_out_q[0].last)
            note_mismatch("group_last", predicted_out_q[0].last, m_axis_tlast);
          if (m_axis_tuser !== {6'b0, predicted_out_q[0].status})
            note_mismatch("status", predicted_out_q[0].status, m_axis_tuser);
          void'(predicted_out_q.pop_front());
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 7);
      end
      // long back-pressure on request
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction anywhere
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  task automatic add_item(input logic [MODE_W-1:0] mode, input logic [SAMPLE_WIDTH-1:0] smp);
    wave_item_t it;
    it.mode = mode;
    it.smp  = smp;
    stim_q.insert(stim_q.size(), it);
  endtask

  // sign flips every few samples, so wavesets average about eight samples
  function automatic logic [SAMPLE_WIDTH-1:0] wave_sample();
    if ($urandom_range(0, 3) == 0) wave_neg = ~wave_neg;
    return {wave_neg, 15'($urandom)};
  endfunction

  // all input consumed and all results back, plus pipeline slack
  task automatic wait_idle();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || s_axis_tvalid || predicted_out_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_group_cycles(input logic [GRP_W-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    grp_reg = v;
  endtask

  // random mix of waveform pushes, drain ticks, flushes, unused-mode items and noise
  task automatic run_wave_phase(input int n_items, input int drain_pct);
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < drain_pct) add_item(MODE_DRAIN, 16'($urandom));
      else if (r < drain_pct + 3) add_item(MODE_FLUSH, 16'($urandom));
      else if (r < drain_pct + 5) add_item(MODE_UNUSED, 16'($urandom));
      else if (r < drain_pct + 10) add_item(MODE_PUSH, 16'($urandom));
      else add_item(MODE_PUSH, wave_sample());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty drain, unused mode, empty flush, sample extremes,
    // overrun on boundary handover and handover on flush (group size 1 after reset)
    add_item(MODE_DRAIN, 16'h0000);
    add_item(MODE_UNUSED, 16'hFFFF);
    add_item(MODE_FLUSH, 16'h0000);
    add_item(MODE_PUSH, 16'h7FFF);
    add_item(MODE_PUSH, 16'h8000);
    add_item(MODE_PUSH, 16'h0000);
    add_item(MODE_PUSH, 16'hFFFF);
    add_item(MODE_PUSH, 16'h0001);
    add_item(MODE_DRAIN, 16'hFFFF);
    add_item(MODE_DRAIN, 16'h0000);
    add_item(MODE_DRAIN, 16'h0000);
    add_item(MODE_PUSH, 16'h5555);
    add_item(MODE_PUSH, 16'hAAAA);
    add_item(MODE_FLUSH, 16'h1234);
    repeat (4) add_item(MODE_DRAIN, 16'h0000);
    add_item(MODE_PUSH, 16'h8000);
    add_item(MODE_PUSH, 16'h7FFF);
    add_item(MODE_DRAIN, 16'h0000);
    add_item(MODE_FLUSH, 16'h0000);
    add_item(MODE_DRAIN, 16'h0000);
    add_item(MODE_DRAIN, 16'h0000);

    // Long output stall while drain ticks keep coming
    write_group_cycles(7'd2);
    repeat (60) add_item(MODE_PUSH, wave_sample());
    add_item(MODE_FLUSH, 16'h0000);
    wait_idle();
    stall_request = 1'b1;
    repeat (40) add_item(MODE_DRAIN, 16'h0000);

    // Random phases over group sizes, extremes included
    foreach (grp_plan[p]) begin
      write_group_cycles(grp_plan[p]);
      no_idle = (p % 4 == 3);
      run_wave_phase(170, 30 + $urandom_range(0, 25));
    end
    wait_idle();
    no_idle = 1'b0;

    // Drain out and let the pipeline settle
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && predicted_out_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
